// ===== rtl/core/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// RPN calculator package
// Command codes, status codes, stack geometry and controller-datapath structs.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int MAX_RESULTS = 32;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] CMD_PUSH = 4'd0;
  localparam logic [3:0] CMD_PEEK = 4'd1;
  localparam logic [3:0] CMD_POP  = 4'd2;
  localparam logic [3:0] CMD_DUMP = 4'd3;
  localparam logic [3:0] CMD_CLR  = 4'd4;
  localparam logic [3:0] CMD_DUP  = 4'd5;
  localparam logic [3:0] CMD_SWAP = 4'd6;
  localparam logic [3:0] CMD_ADD  = 4'd7;
  localparam logic [3:0] CMD_SUB  = 4'd8;
  localparam logic [3:0] CMD_MUL  = 4'd9;
  localparam logic [3:0] CMD_DIV  = 4'd10;
  localparam logic [3:0] CMD_MOD  = 4'd11;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [1:0]    wr_sel;   // 0 push value, 1 operand b, 2 operand a, 3 alu result
    logic          ld_in;
    logic          ld_b;     // capture read data as top operand
    logic          ld_a;     // capture read data as next operand
    logic          alu_go;
  } rpn_cmd_t;

  localparam logic [1:0] WS_IN  = 2'd0;
  localparam logic [1:0] WS_B   = 2'd1;
  localparam logic [1:0] WS_A   = 2'd2;
  localparam logic [1:0] WS_ALU = 2'd3;

  typedef struct packed {
    logic        alu_done;
    logic        b_zero;
    logic [31:0] rd_data;
  } rpn_stat_t;

endpackage

// ===== rtl/core/rpn_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== rtl/core/rpn_alu.sv =====
// ----------------------------------------------------------------------------
// RPN arithmetic unit
// Add, subtract and multiply with a registered result; signed divide and modulo by a
// restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpn_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [3:0]  op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] res
);
  import rpn_pkg::*;

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, div_r, div_nxt;
  logic        qneg_r, qneg_nxt, rneg_r, rneg_nxt, mod_r, mod_nxt;
  logic        done_r, done_nxt;
  logic [31:0] res_r, res_nxt;
  logic [32:0] trial;
  logic [31:0] absa, absb;

  assign absa = a[31] ? 32'(-a) : a;
  assign absb = b[31] ? 32'(-b) : b;
  assign trial = {rem_r, quo_r[31]} - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    mod_nxt  = mod_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    if (go) begin
      case (op)
        CMD_ADD: begin
          res_nxt  = a + b;
          done_nxt = 1'b1;
        end
        CMD_SUB: begin
          res_nxt  = a - b;
          done_nxt = 1'b1;
        end
        CMD_MUL: begin
          res_nxt  = 32'(a * b);
          done_nxt = 1'b1;
        end
        default: begin
          busy_nxt = 1'b1;
          cnt_nxt  = 6'd0;
          rem_nxt  = '0;
          quo_nxt  = absa;
          div_nxt  = absb;
          qneg_nxt = a[31] ^ b[31];
          rneg_nxt = a[31];
          mod_nxt  = (op == CMD_MOD);
        end
      endcase
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (mod_r) begin
          res_nxt = rneg_r ? 32'(-rem_nxt) : rem_nxt;
        end else begin
          res_nxt = qneg_r ? 32'(-quo_nxt) : quo_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    div_r  <= div_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
    mod_r  <= mod_nxt;
    res_r  <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;
endmodule

// ===== rtl/core/rpn_datapath.sv =====
// ----------------------------------------------------------------------------
// RPN datapath
// Stack memory, operand registers and the arithmetic unit.
// ----------------------------------------------------------------------------
module rpn_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        op,
  input  logic [31:0]       push_value,
  input  rpn_pkg::rpn_cmd_t cmd,
  output rpn_pkg::rpn_stat_t stat
);
  import rpn_pkg::*;

  logic [31:0] in_r, a_r, b_r, rd_data, wr_data, alu_res;
  logic        alu_done;

  always_comb begin
    case (cmd.wr_sel)
      WS_IN:   wr_data = in_r;
      WS_B:    wr_data = b_r;
      WS_A:    wr_data = a_r;
      default: wr_data = alu_res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      in_r <= push_value;
    end
    if (cmd.ld_b) begin
      b_r <= rd_data;
    end
    if (cmd.ld_a) begin
      a_r <= rd_data;
    end
  end

  rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .wr_en(cmd.wr_en), .wr_addr(cmd.wr_addr), .wr_data(wr_data),
    .rd_en(cmd.rd_en), .rd_addr(cmd.rd_addr), .rd_data(rd_data)
  );

  rpn_alu u_alu (
    .clk(clk), .rst_n(rst_n), .go(cmd.alu_go), .op(op), .a(a_r), .b(b_r),
    .done(alu_done), .res(alu_res)
  );

  assign stat.alu_done = alu_done;
  assign stat.b_zero   = (b_r == 32'd0);
  assign stat.rd_data  = rd_data;
endmodule

// ===== rtl/core/rpn_ctrl.sv =====
// ----------------------------------------------------------------------------
// RPN controller
// Decodes a command, sequences stack reads and writes, and emits result beats.
// ----------------------------------------------------------------------------
module rpn_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [3:0]         req,
  output logic               busy,
  output logic [3:0]         op,
  output rpn_pkg::rpn_cmd_t  cmd,
  input  rpn_pkg::rpn_stat_t stat,
  output logic               out_valid,
  output logic [31:0]        out_value,
  output logic               out_has,
  output logic [1:0]         out_status,
  output logic               out_last
);
  import rpn_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;  // top read issued
  localparam logic [2:0] S_RD2  = 3'd2;  // next read issued
  localparam logic [2:0] S_EXEC = 3'd3;  // operands held
  localparam logic [2:0] S_ALU  = 3'd4;
  localparam logic [2:0] S_DUMP = 3'd5;

  localparam int RW = $clog2(MAX_RESULTS + 1);

  logic [2:0]    state_r, state_nxt;
  logic [3:0]    op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [RW-1:0] left_r, left_nxt;
  logic          ov_r, ov_nxt;
  logic [31:0]   val_r, val_nxt;
  logic          has_r, has_nxt;
  logic [1:0]    st_r, st_nxt;
  logic          last_r, last_nxt;
  logic [CW-1:0] ncnt;

  assign ncnt = (cnt_r > CW'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : cnt_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    left_nxt  = left_r;
    ov_nxt    = 1'b0;
    val_nxt   = val_r;
    has_nxt   = 1'b0;
    st_nxt    = ST_OK;
    last_nxt  = 1'b1;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt     = req;
          cmd.ld_in  = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_addr = AW'(cnt_r - CW'(1));
          val_nxt    = '0;
          case (req)
            CMD_PUSH: begin
              if (cnt_r >= CW'(STACK_DEPTH)) begin
                ov_nxt = 1'b1; st_nxt = ST_OVER;
              end else begin
                state_nxt = S_EXEC;
              end
            end
            CMD_CLR: begin
              cnt_nxt = '0; ov_nxt = 1'b1;
            end
            CMD_DUMP: begin
              if (cnt_r == '0) begin
                ov_nxt = 1'b1;
              end else begin
                idx_nxt   = cnt_r - CW'(1);
                left_nxt  = RW'(ncnt);
                state_nxt = S_RD1;
              end
            end
            CMD_PEEK, CMD_POP, CMD_DUP: begin
              if (cnt_r == '0) begin
                ov_nxt = 1'b1; st_nxt = ST_UNDER;
              end else if (req == CMD_DUP && cnt_r >= CW'(STACK_DEPTH)) begin
                ov_nxt = 1'b1; st_nxt = ST_OVER;
              end else begin
                state_nxt = S_RD1;
              end
            end
            CMD_SWAP, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
              if (cnt_r == '0) begin
                ov_nxt = 1'b1; st_nxt = ST_UNDER;
              end else if (cnt_r == CW'(1)) begin
                ov_nxt = 1'b1; st_nxt = ST_UNDER;
                if (req == CMD_SWAP) begin
                  cnt_nxt = '0;
                end
              end else begin
                state_nxt = S_RD1;
              end
            end
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      S_RD1: begin
        if (op_r == CMD_DUMP) begin
          state_nxt = S_DUMP;
        end else if (op_r == CMD_PEEK || op_r == CMD_POP || op_r == CMD_DUP) begin
          cmd.ld_b  = 1'b1;
          state_nxt = S_EXEC;
        end else begin
          cmd.ld_b    = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = AW'(cnt_r - CW'(2));
          state_nxt   = S_RD2;
        end
      end
      S_RD2: begin
        cmd.ld_a  = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (op_r)
          CMD_PUSH: begin
            cmd.wr_en = 1'b1; cmd.wr_addr = AW'(cnt_r); cmd.wr_sel = WS_IN;
            cnt_nxt = cnt_r + CW'(1); ov_nxt = 1'b1;
          end
          CMD_PEEK, CMD_POP: begin
            ov_nxt = 1'b1; has_nxt = 1'b1; val_nxt = stat.rd_data;
            if (op_r == CMD_POP) begin
              cnt_nxt = cnt_r - CW'(1);
            end
          end
          CMD_DUP: begin
            cmd.wr_en = 1'b1; cmd.wr_addr = AW'(cnt_r); cmd.wr_sel = WS_B;
            cnt_nxt = cnt_r + CW'(1); ov_nxt = 1'b1;
          end
          CMD_SWAP: begin
            // The second write lands in the ALU state, which is idle for swap.
            cmd.wr_en = 1'b1; cmd.wr_addr = AW'(cnt_r - CW'(1)); cmd.wr_sel = WS_A;
            state_nxt = S_ALU;
          end
          default: begin
            if ((op_r == CMD_DIV || op_r == CMD_MOD) && stat.b_zero) begin
              cnt_nxt = cnt_r - CW'(2); ov_nxt = 1'b1; st_nxt = ST_DIVZ;
            end else begin
              cmd.alu_go = 1'b1;
              state_nxt  = S_ALU;
            end
          end
        endcase
      end
      S_ALU: begin
        if (op_r == CMD_SWAP) begin
          cmd.wr_en = 1'b1; cmd.wr_addr = AW'(cnt_r - CW'(2)); cmd.wr_sel = WS_B;
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else if (stat.alu_done) begin
          cmd.wr_en = 1'b1; cmd.wr_addr = AW'(cnt_r - CW'(2)); cmd.wr_sel = WS_ALU;
          cnt_nxt = cnt_r - CW'(1); ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        // Read data for idx_r is ready now; the next read goes out alongside.
        ov_nxt   = 1'b1;
        has_nxt  = 1'b1;
        val_nxt  = stat.rd_data;
        left_nxt = left_r - RW'(1);
        idx_nxt  = idx_r - CW'(1);
        last_nxt = (left_r == RW'(1));
        if (left_r == RW'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = AW'(idx_r - CW'(1));
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    op_r   <= op_nxt;
    idx_r  <= idx_nxt;
    left_r <= left_nxt;
    val_r  <= val_nxt;
    has_r  <= has_nxt;
    st_r   <= st_nxt;
    last_r <= last_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign op         = op_r;
  assign out_valid  = ov_r;
  assign out_value  = has_r ? val_r : 32'd0;
  assign out_has    = has_r;
  assign out_status = st_r;
  assign out_last   = last_r;
endmodule

// ===== rtl/core/rpn_stack_calculator.sv =====
// ----------------------------------------------------------------------------
// RPN stack calculator
// Reverse-Polish integer calculator over a bounded stack of 32-bit words.
// ----------------------------------------------------------------------------
// Usage: drive in_req_type and in_push_value with start high; the command is
// taken at a clock edge where busy is low. Each result beat appears on the
// out_ ports for one cycle with out_valid high; out_last marks the final beat
// of a command. The receiver cannot stall, so every beat must be taken.
// Sequencing: commands that end early (errors, clear, unused codes) give their
// beat in the cycle after acceptance and busy stays low. Push writes in the
// execute state; peek, pop and dup read the top entry, swap and arithmetic
// read both operands and end in the ALU state (divide and modulo once the
// divider is done); division by zero ends in execute. Dump gives one beat per
// entry, top first. Busy drops in the cycle the last beat shows, so the next
// command can follow. Reset clears the stack count; the stack RAM itself is
// not cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module rpn_stack_calculator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_req_type,
  input  logic signed [31:0] in_push_value,
  output logic        out_valid,
  output logic signed [31:0] out_result_value,
  output logic        out_has_value,
  output logic [1:0]  out_status,
  output logic        out_last
);
  import rpn_pkg::*;

  rpn_cmd_t    cmd;
  rpn_stat_t   stat;
  logic [3:0]  op;
  logic [31:0] value;

  // The controller owns the stack count and the sequencing of each command.
  rpn_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .req(in_req_type), .busy(busy),
    .op(op), .cmd(cmd), .stat(stat), .out_valid(out_valid), .out_value(value),
    .out_has(out_has_value), .out_status(out_status), .out_last(out_last)
  );

  // The datapath holds the stack memory, operand registers and the ALU.
  rpn_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .op(op), .push_value(in_push_value),
    .cmd(cmd), .stat(stat)
  );

  assign out_result_value = value;
endmodule

// ===== rtl/core/rpn_checker.sv =====
// ----------------------------------------------------------------------------
// RPN port checker
// Watches the top-level ports for result framing errors.
// ----------------------------------------------------------------------------
module rpn_props (
  input logic        clk,
  input logic        rst_n,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_result_value,
  input logic        out_has_value,
  input logic [1:0]  out_status,
  input logic        out_last
);
  import rpn_pkg::*;

  // A beat without a value carries zero.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_value |-> out_result_value == 32'd0)
    else $error("value without has_value");

  // A printed beat always reports success.
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_value |-> out_status == ST_OK)
    else $error("printed beat with error status");

  // A non-final beat is followed directly by another beat.
  a_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("dump beats broke off");

  // While more beats of a command are due, no new command can be taken.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("idle while dump beats remain");

  // An error beat is always the only beat of its command.
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("error beat not last");
endmodule

bind rpn_stack_calculator rpn_props u_rpn_props (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_result_value(out_result_value), .out_has_value(out_has_value),
  .out_status(out_status), .out_last(out_last)
);
